>>> rtl/rfpq_pkg.sv
// ----------------------------------------------------------------------------
// rfpq_pkg : shared definitions for the range flip / point query bit string
// widths of the request fields, action codes and the tree command interface
// ----------------------------------------------------------------------------
package rfpq_pkg;

	localparam int unsigned POS_W       = 13;
	localparam int unsigned IDX_W       = POS_W + 1;
	localparam int unsigned POS_MAX     = (2 ** POS_W) - 1;
	localparam int unsigned MAX_LEN_DEF = 4096;
	localparam logic [POS_W-1:0] LEN_RESET = 13'd4096;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_WRITE  = 2'd1;
	localparam logic [1:0] ACT_INVERT = 2'd2;
	localparam logic [1:0] ACT_QUERY  = 2'd3;

	typedef struct packed {
		logic             start;
		logic [1:0]       op;
		logic [IDX_W-1:0] idx_a;
		logic [IDX_W-1:0] idx_b;
		logic [POS_W-1:0] len;
	} tree_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic parity;
	} tree_sts_t;

	// lowest set bit of a tree index
	function automatic logic [IDX_W-1:0] low_bit(input logic [IDX_W-1:0] v);
		return v & (~v + IDX_W'(1));
	endfunction

endpackage

>>> rtl/rfpq_tree.sv
// ----------------------------------------------------------------------------
// rfpq_tree : fenwick parity tree in one synchronous memory
// clearing sweep, toggle walks upward and prefix parity walk downward
// ----------------------------------------------------------------------------
module rfpq_tree
	import rfpq_pkg::*;
#(
	parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  tree_cmd_t cmd,
	output tree_sts_t sts
);

	localparam int unsigned AW = $clog2(MAX_LEN + 1);

	localparam logic [2:0] T_SWEEP = 3'd0;
	localparam logic [2:0] T_IDLE  = 3'd1;
	localparam logic [2:0] T_TRD   = 3'd2;
	localparam logic [2:0] T_TWR   = 3'd3;
	localparam logic [2:0] T_QWALK = 3'd4;

	logic [2:0]       st_q, st_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [IDX_W-1:0] idx_b_q, idx_b_d;
	logic             second_q, second_d;
	logic [POS_W-1:0] len_q, len_d;
	logic             par_q, par_d;
	logic             rv_s1, rv_d;
	logic [AW-1:0]    clr_q, clr_d;

	logic          tree_mem [0:MAX_LEN];
	logic          rdata_s1;
	logic          we, re, wd;
	logic [AW-1:0] wa, ra;

	logic [IDX_W-1:0] len_x;
	logic [IDX_W-1:0] up_idx;
	logic [IDX_W-1:0] dn_idx;
	logic             idx_live;
	logic             up_live;
	logic             done;

	assign len_x    = IDX_W'(len_q);
	assign up_idx   = idx_q + low_bit(idx_q);
	assign dn_idx   = idx_q - low_bit(idx_q);
	assign idx_live = (idx_q != '0) && (idx_q <= len_x);
	assign up_live  = (up_idx <= len_x);

	always_comb begin
		st_d     = st_q;
		idx_d    = idx_q;
		idx_b_d  = idx_b_q;
		second_d = second_q;
		len_d    = len_q;
		par_d    = par_q;
		rv_d     = 1'b0;
		clr_d    = clr_q;
		we       = 1'b0;
		wa       = AW'(idx_q);
		wd       = 1'b0;
		re       = 1'b0;
		ra       = AW'(idx_q);
		done     = 1'b0;
		case (st_q)
			T_SWEEP: begin
				we    = 1'b1;
				wa    = clr_q;
				clr_d = clr_q + AW'(1);
				if (clr_q == AW'(MAX_LEN)) begin
					st_d = T_IDLE;
				end
			end
			T_IDLE: begin
				if (cmd.start) begin
					idx_d    = cmd.idx_a;
					idx_b_d  = cmd.idx_b;
					len_d    = cmd.len;
					second_d = 1'b0;
					par_d    = 1'b0;
					case (cmd.op)
						ACT_CLEAR: begin
							clr_d = '0;
							st_d  = T_SWEEP;
						end
						ACT_INVERT: st_d = T_TRD;
						ACT_QUERY:  st_d = T_QWALK;
						default:    st_d = T_IDLE;
					endcase
				end
			end
			T_TRD: begin
				if (idx_live) begin
					re   = 1'b1;
					st_d = T_TWR;
				end else if (!second_q) begin
					// second walk starts just past the range end
					idx_d    = idx_b_q;
					second_d = 1'b1;
				end else begin
					done = 1'b1;
					st_d = T_IDLE;
				end
			end
			T_TWR: begin
				we    = 1'b1;
				wd    = ~rdata_s1;
				idx_d = up_idx;
				if (up_live) begin
					re = 1'b1;
					ra = AW'(up_idx);
				end else begin
					st_d = T_TRD;
				end
			end
			T_QWALK: begin
				if (rv_s1) begin
					par_d = par_q ^ rdata_s1;
				end
				if (idx_q != '0) begin
					re    = 1'b1;
					rv_d  = 1'b1;
					idx_d = dn_idx;
				end else if (!rv_s1) begin
					done = 1'b1;
					st_d = T_IDLE;
				end
			end
			default: st_d = T_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= T_SWEEP;
			clr_q    <= '0;
			rv_s1    <= 1'b0;
			second_q <= 1'b0;
		end else begin
			st_q     <= st_d;
			clr_q    <= clr_d;
			rv_s1    <= rv_d;
			second_q <= second_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q   <= idx_d;
		idx_b_q <= idx_b_d;
		len_q   <= len_d;
		par_q   <= par_d;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			tree_mem[wa] <= wd;
		end
		if (re) begin
			rdata_s1 <= tree_mem[ra];
		end
	end

	assign sts.busy   = (st_q != T_IDLE);
	assign sts.done   = done;
	assign sts.parity = par_q;

	// write-back and next read in the same cycle never share an entry
	a_rmw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(we && re) |-> (wa != ra))
		else $error("tree read and write hit the same entry");

	// toggle write-back stays inside the current walk bound
	a_twr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == T_TWR) |-> ((idx_q != '0) && (idx_q <= len_x)))
		else $error("toggle walk left the tree bound");

	// a read issued in the parity walk is consumed on the next cycle
	a_q_consume: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == T_QWALK) && re) |=> ((st_q == T_QWALK) && rv_s1))
		else $error("parity walk lost a tree read");

endmodule

>>> rtl/range_flip_point_query_bits_core.sv
// ----------------------------------------------------------------------------
// range_flip_point_query_bits_core : range invert / point query bit string
// bit store plus fenwick flip-parity tree, one request in flight at a time
// ----------------------------------------------------------------------------
//
//  channel   handshake             payload
//  --------  --------------------  ---------------------------------------
//  request   in_valid / in_ready   action, position, range_end, bit_in
//  result    out_valid / out_ready bit_value, out_of_range
//  config    cfg_we                cfg_wdata (string length, 13 bits)
//
//  write and rejected requests: no tree walk; a bad query: straight to the result
//  query: a downward parity walk, one tree memory read per cycle
//  invert: an upward toggle walk from position and one past range_end, one
//    read-modify-write of the tree memory per node, on the single port pair
//  clear and reset: a sweep over all MAX_LEN + 1 entries of the tree memory,
//    no request taken meanwhile (config writes still taken)
//  a finished result waits in the output register while the next request runs
//
module range_flip_point_query_bits_core
	import rfpq_pkg::*;
#(
	parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       action,
	input  logic [POS_W-1:0] position,
	input  logic [POS_W-1:0] range_end,
	input  logic             bit_in,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             bit_value,
	output logic             out_of_range,
	input  logic             cfg_we,
	input  logic [POS_W-1:0] cfg_wdata
);

	localparam int unsigned AW      = $clog2(MAX_LEN + 1);
	localparam int unsigned LEN_CAP = (MAX_LEN < POS_MAX) ? MAX_LEN : POS_MAX;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_TREE = 2'd1;
	localparam logic [1:0] S_RES  = 2'd2;

	logic [POS_W-1:0] cfg_len_q;
	logic [POS_W-1:0] eff_len;

	logic [1:0] st_q;
	logic       qry_q;
	logic       res_bit_q;
	logic       res_oor_q;
	logic       out_valid_q;
	logic       bit_value_q;
	logic       out_of_range_q;

	logic      in_acc;
	logic      pos_ok;
	logic      inv_ok;
	logic      out_free;
	tree_cmd_t tree_cmd;
	tree_sts_t tree_sts;

	// bit store, undefined until written
	logic bit_mem [0:MAX_LEN];
	logic bit_rd_s1;
	logic bit_we;
	logic bit_re;

	// config register, length saturated to the store size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_len_q <= LEN_RESET;
		end else if (cfg_we) begin
			cfg_len_q <= cfg_wdata;
		end
	end

	assign eff_len = (32'(cfg_len_q) > LEN_CAP) ? POS_W'(LEN_CAP) : cfg_len_q;

	// request decode
	assign in_ready = (st_q == S_IDLE) && !tree_sts.busy;
	assign in_acc   = in_valid && in_ready;
	assign pos_ok   = (position != '0) && (position <= eff_len);
	assign inv_ok   = (position != '0) && (position <= range_end) && (range_end <= eff_len);

	assign bit_we = in_acc && (action == ACT_WRITE) && pos_ok;
	assign bit_re = in_acc && (action == ACT_QUERY) && pos_ok;

	always_ff @(posedge clk) begin
		if (bit_we) begin
			bit_mem[AW'(position)] <= bit_in;
		end
		if (bit_re) begin
			bit_rd_s1 <= bit_mem[AW'(position)];
		end
	end

	// tree command: clear, valid invert, valid query
	always_comb begin
		tree_cmd.op    = action;
		tree_cmd.idx_a = IDX_W'(position);
		tree_cmd.idx_b = IDX_W'(range_end) + IDX_W'(1);
		tree_cmd.len   = eff_len;
		tree_cmd.start = 1'b0;
		if (in_acc) begin
			case (action)
				ACT_CLEAR:  tree_cmd.start = 1'b1;
				ACT_INVERT: tree_cmd.start = inv_ok;
				ACT_QUERY:  tree_cmd.start = pos_ok;
				default:    tree_cmd.start = 1'b0;
			endcase
		end
	end

	rfpq_tree #(
		.MAX_LEN (MAX_LEN)
	) u_tree (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (tree_cmd),
		.sts    (tree_sts)
	);

	// output register slot is free or being emptied this cycle
	assign out_free = !out_valid_q || out_ready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			qry_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// in the result state the slot is either refilled or still full
			if (out_valid_q && out_ready && (st_q != S_RES)) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (in_acc) begin
						qry_q <= (action == ACT_QUERY);
						// a clear sweep is held off by the tree busy flag alone
						if (tree_cmd.start && (action != ACT_CLEAR)) begin
							st_q <= S_TREE;
						end else if (action == ACT_QUERY) begin
							// bad query position goes straight to the result
							st_q <= S_RES;
						end
					end
				end
				S_TREE: begin
					if (tree_sts.done) begin
						st_q <= qry_q ? S_RES : S_IDLE;
					end
				end
				S_RES: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						st_q        <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_acc && (action == ACT_QUERY)) begin
			res_bit_q <= 1'b0;
			res_oor_q <= !pos_ok;
		end else if ((st_q == S_TREE) && tree_sts.done) begin
			res_bit_q <= bit_rd_s1 ^ tree_sts.parity;
		end
		if ((st_q == S_RES) && out_free) begin
			bit_value_q    <= res_bit_q;
			out_of_range_q <= res_oor_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign bit_value    = bit_value_q;
	assign out_of_range = out_of_range_q;

	// tree only finishes work that the sequencer is waiting on
	a_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		tree_sts.done |-> (st_q == S_TREE))
		else $error("tree finished with no request waiting");

	// an out-of-range result always carries a zero bit
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_of_range_q && bit_value_q))
		else $error("out-of-range result with a set bit");

	// a result is only loaded when the output slot is free
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == S_RES) && out_valid_q && !out_ready) |=> (st_q == S_RES))
		else $error("result overran a waiting output");

endmodule
